### rtl/core/sd_card_spi_host_sequencer_macros.svh
//------------------------------------------------------------------------------
// sd_card_spi_host_sequencer_macros
// Assertion helper macros for the SD card SPI host sequencer.
//------------------------------------------------------------------------------
`ifndef SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SDS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/sds_pkg.sv
//------------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the SD card SPI host sequencer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package sds_pkg;

    typedef enum logic [5:0] {
        PH_IDLE, PH_PRIME, PH_BUSY_INIT, PH_BUSY_COUNT, PH_BUSY_READ, PH_BUSY_WRITE,
        PH_CMD0, PH_CMD8, PH_CMD55A, PH_ACMD41A, PH_CMD55L, PH_ACMD41L, PH_CMD58,
        PH_CMD16, PH_CMD9, PH_CMD17, PH_CMD24, PH_R7, PH_OCR, PH_TOKEN_COUNT,
        PH_TOKEN_READ, PH_CSD, PH_DATA, PH_WDATA, PH_WCRC, PH_WRESP
    } phase_t;

    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_COUNT = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;

    localparam logic [3:0] ST_BUSY       = 4'd0;
    localparam logic [3:0] ST_OK         = 4'd1;
    localparam logic [3:0] ST_CMD0       = 4'd2;
    localparam logic [3:0] ST_CMD8       = 4'd3;
    localparam logic [3:0] ST_ECHO       = 4'd4;
    localparam logic [3:0] ST_CMD55A     = 4'd5;
    localparam logic [3:0] ST_CMD55L     = 4'd6;
    localparam logic [3:0] ST_RETRY      = 4'd7;
    localparam logic [3:0] ST_CMD58      = 4'd8;
    localparam logic [3:0] ST_CMD16      = 4'd9;
    localparam logic [3:0] ST_POWER      = 4'd10;
    localparam logic [3:0] ST_R1         = 4'd11;
    localparam logic [3:0] ST_TOKEN      = 4'd12;
    localparam logic [3:0] ST_DATA_RESP  = 4'd13;

    localparam logic [0:0] CFG_POLL_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_START_TOKEN = 1'b1;

    localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
    localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;
    localparam logic [31:0] ARG_CMD16  = 32'h0000_0200;
    localparam logic [7:0]  CRC_CMD0   = 8'h4A;
    localparam logic [7:0]  CRC_CMD8   = 8'h43;
    localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
    localparam int FRAME_BYTES = 6;
    localparam int CSD_BYTES   = 18;
    localparam int CRC_BYTES   = 2;

    // Result of one step.
    typedef struct packed {
        logic [7:0]  transmit_byte;
        logic        select_active;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        need_write_byte;
        logic [3:0]  status;
        logic [31:0] block_count;
        logic        last;
    } result_t;

    // Sequencer state.
    typedef struct packed {
        phase_t      phase;
        logic [9:0]  byte_counter;
        logic [15:0] poll_counter;
        logic [31:0] response_shift;
        logic [31:0] command_argument;
        logic [21:0] capacity_field;
        logic [15:0] acmd_retry;
    } seq_state_t;

endpackage

### rtl/core/sds_step.sv
//------------------------------------------------------------------------------
// sds_step
// Combinational next-state and result logic for one byte exchange.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sds_step #(
    parameter int BLOCK_BYTES = 512,
    parameter int PRIME_BYTES = 10
) (
    input  sds_pkg::seq_state_t st,
    input  logic [2:0]          command,
    input  logic [31:0]         block_address,
    input  logic [7:0]          received_byte,
    input  logic [7:0]          write_byte,
    input  logic [15:0]         poll_limit,
    input  logic [7:0]          start_token,
    output sds_pkg::seq_state_t st_next,
    output sds_pkg::result_t    res
);

    logic [15:0] lim;
    assign lim = (poll_limit == 16'd0) ? 16'd1 : poll_limit;

    function automatic logic [5:0] cmd_index(input sds_pkg::phase_t ph);
        case (ph)
            sds_pkg::PH_CMD0:   return 6'd0;
            sds_pkg::PH_CMD8:   return 6'd8;
            sds_pkg::PH_CMD55A, sds_pkg::PH_CMD55L:   return 6'd55;
            sds_pkg::PH_ACMD41A, sds_pkg::PH_ACMD41L: return 6'd41;
            sds_pkg::PH_CMD58:  return 6'd58;
            sds_pkg::PH_CMD16:  return 6'd16;
            sds_pkg::PH_CMD9:   return 6'd9;
            sds_pkg::PH_CMD17:  return 6'd17;
            default:            return 6'd24;
        endcase
    endfunction

    function automatic logic [7:0] frame_byte(input sds_pkg::phase_t ph,
                                              input logic [31:0] arg,
                                              input logic [2:0] k);
        logic [7:0] crc;
        crc = 8'h00;
        case (k)
            3'd0: return {2'b01, cmd_index(ph)};
            3'd1: return arg[31:24];
            3'd2: return arg[23:16];
            3'd3: return arg[15:8];
            3'd4: return arg[7:0];
            default: begin
                if (ph == sds_pkg::PH_CMD0) crc = sds_pkg::CRC_CMD0;
                else if (ph == sds_pkg::PH_CMD8) crc = sds_pkg::CRC_CMD8;
                return {crc[6:0], 1'b1};
            end
        endcase
    endfunction

    always_comb begin
        logic [7:0]  r1;
        logic [31:0] shifted;
        logic [9:0]  cnt_inc;
        logic        do_r1;
        logic [21:0] cap_sum;
        sds_pkg::phase_t nph;
        logic [31:0] narg;
        logic        begin_frame;
        logic        fin;
        logic [3:0]  fin_code;

        st_next = st;
        res = '0;
        res.transmit_byte = sds_pkg::IDLE_BYTE;
        res.select_active = 1'b1;
        r1 = received_byte;
        do_r1 = 1'b0;
        shifted = {st.response_shift[23:0], received_byte};
        cnt_inc = st.byte_counter + 10'd1;
        cap_sum = st.capacity_field + 22'd1;
        nph = sds_pkg::PH_IDLE;
        narg = 32'd0;
        begin_frame = 1'b0;
        fin = 1'b0;
        fin_code = sds_pkg::ST_BUSY;

        if (command <= sds_pkg::CMD_WRITE) begin
            st_next.byte_counter = 10'd0;
            st_next.poll_counter = 16'd0;
            if (command == sds_pkg::CMD_INIT) begin
                st_next.phase = sds_pkg::PH_PRIME;
                st_next.byte_counter = 10'd1;
                res.select_active = 1'b0;
            end else begin
                st_next.command_argument = block_address;
                case (command)
                    sds_pkg::CMD_COUNT: st_next.phase = sds_pkg::PH_BUSY_COUNT;
                    sds_pkg::CMD_READ:  st_next.phase = sds_pkg::PH_BUSY_READ;
                    default:            st_next.phase = sds_pkg::PH_BUSY_WRITE;
                endcase
            end
        end else begin
            case (st.phase)
                sds_pkg::PH_IDLE: res.select_active = 1'b0;
                sds_pkg::PH_PRIME: begin
                    if (st.byte_counter < 10'(PRIME_BYTES)) begin
                        st_next.byte_counter = cnt_inc;
                        res.select_active = 1'b0;
                    end else st_next.phase = sds_pkg::PH_BUSY_INIT;
                end
                sds_pkg::PH_BUSY_INIT, sds_pkg::PH_BUSY_COUNT,
                sds_pkg::PH_BUSY_READ, sds_pkg::PH_BUSY_WRITE: begin
                    if (received_byte == 8'hFF) begin
                        begin_frame = 1'b1;
                        case (st.phase)
                            sds_pkg::PH_BUSY_INIT:  nph = sds_pkg::PH_CMD0;
                            sds_pkg::PH_BUSY_COUNT: nph = sds_pkg::PH_CMD9;
                            sds_pkg::PH_BUSY_READ: begin
                                nph = sds_pkg::PH_CMD17; narg = st.command_argument;
                            end
                            default: begin
                                nph = sds_pkg::PH_CMD24; narg = st.command_argument;
                            end
                        endcase
                    end
                end
                sds_pkg::PH_CMD0, sds_pkg::PH_CMD8, sds_pkg::PH_CMD55A,
                sds_pkg::PH_ACMD41A, sds_pkg::PH_CMD55L, sds_pkg::PH_ACMD41L,
                sds_pkg::PH_CMD58, sds_pkg::PH_CMD16, sds_pkg::PH_CMD9,
                sds_pkg::PH_CMD17, sds_pkg::PH_CMD24: begin
                    if (st.byte_counter < 10'(sds_pkg::FRAME_BYTES)) begin
                        res.transmit_byte = frame_byte(st.phase, st.command_argument,
                                                       st.byte_counter[2:0]);
                        st_next.byte_counter = cnt_inc;
                    end else if (st.byte_counter == 10'(sds_pkg::FRAME_BYTES)) begin
                        st_next.byte_counter = 10'(sds_pkg::FRAME_BYTES + 1);
                        st_next.poll_counter = 16'd1;
                    end else if (received_byte != 8'hFF) begin
                        do_r1 = 1'b1;
                    end else if (st.poll_counter >= lim) begin
                        do_r1 = 1'b1;
                    end else st_next.poll_counter = st.poll_counter + 16'd1;
                end
                sds_pkg::PH_R7, sds_pkg::PH_OCR: begin
                    st_next.response_shift = shifted;
                    st_next.byte_counter = cnt_inc;
                    if (cnt_inc >= 10'd4) begin
                        if (st.phase == sds_pkg::PH_R7) begin
                            if (shifted[15:0] == sds_pkg::ARG_CMD8[15:0]) begin
                                begin_frame = 1'b1; nph = sds_pkg::PH_CMD55A;
                            end else begin
                                fin = 1'b1; fin_code = sds_pkg::ST_ECHO;
                            end
                        end else if (shifted[31:30] == 2'b11) begin
                            fin = 1'b1; fin_code = sds_pkg::ST_OK;
                        end else if (shifted[31]) begin
                            begin_frame = 1'b1; nph = sds_pkg::PH_CMD16;
                            narg = sds_pkg::ARG_CMD16;
                        end else begin
                            fin = 1'b1; fin_code = sds_pkg::ST_POWER;
                        end
                    end
                end
                sds_pkg::PH_TOKEN_COUNT, sds_pkg::PH_TOKEN_READ: begin
                    if (received_byte == start_token) begin
                        st_next.phase = (st.phase == sds_pkg::PH_TOKEN_COUNT) ?
                                        sds_pkg::PH_CSD : sds_pkg::PH_DATA;
                        st_next.byte_counter = 10'd0;
                        st_next.response_shift = 32'd0;
                        st_next.capacity_field = 22'd0;
                    end else if (received_byte != 8'hFF || st.poll_counter >= lim) begin
                        fin = 1'b1; fin_code = sds_pkg::ST_TOKEN;
                    end else st_next.poll_counter = st.poll_counter + 16'd1;
                end
                sds_pkg::PH_CSD: begin
                    if (st.byte_counter == 10'd7)
                        st_next.capacity_field = {16'd0, received_byte[5:0]};
                    else if (st.byte_counter == 10'd8 || st.byte_counter == 10'd9)
                        st_next.capacity_field = {st.capacity_field[13:0], received_byte};
                    st_next.byte_counter = cnt_inc;
                    if (cnt_inc >= 10'(sds_pkg::CSD_BYTES)) begin
                        fin = 1'b1; fin_code = sds_pkg::ST_OK;
                    end
                end
                sds_pkg::PH_DATA: begin
                    if (st.byte_counter < 10'(BLOCK_BYTES)) begin
                        res.read_byte = received_byte;
                        res.read_valid = 1'b1;
                    end
                    st_next.byte_counter = cnt_inc;
                    if (cnt_inc >= 10'(BLOCK_BYTES + sds_pkg::CRC_BYTES)) begin
                        fin = 1'b1; fin_code = sds_pkg::ST_OK;
                    end
                end
                sds_pkg::PH_WDATA: begin
                    res.transmit_byte = write_byte;
                    st_next.byte_counter = cnt_inc;
                    if (cnt_inc < 10'(BLOCK_BYTES)) res.need_write_byte = 1'b1;
                    else begin
                        st_next.phase = sds_pkg::PH_WCRC;
                        st_next.byte_counter = 10'd0;
                    end
                end
                sds_pkg::PH_WCRC: begin
                    st_next.byte_counter = cnt_inc;
                    if (cnt_inc > 10'(sds_pkg::CRC_BYTES)) begin
                        st_next.phase = sds_pkg::PH_WRESP;
                        st_next.poll_counter = 16'd1;
                    end
                end
                sds_pkg::PH_WRESP: begin
                    if (received_byte[4:0] == 5'h05) begin
                        fin = 1'b1; fin_code = sds_pkg::ST_OK;
                    end else if (st.poll_counter >= lim) begin
                        fin = 1'b1; fin_code = sds_pkg::ST_DATA_RESP;
                    end else st_next.poll_counter = st.poll_counter + 16'd1;
                end
                default: begin
                    st_next.phase = sds_pkg::PH_IDLE;
                    st_next.byte_counter = 10'd0;
                    st_next.poll_counter = 16'd0;
                    res.select_active = 1'b0;
                end
            endcase
        end

        // R1 handling; a timed-out poll reads as the idle byte.
        if (do_r1) begin
            case (st.phase)
                sds_pkg::PH_CMD0: if (r1 == 8'd1) begin
                    begin_frame = 1'b1; nph = sds_pkg::PH_CMD8; narg = sds_pkg::ARG_CMD8;
                end else begin fin = 1'b1; fin_code = sds_pkg::ST_CMD0; end
                sds_pkg::PH_CMD8: if (r1 == 8'd1) begin
                    st_next.phase = sds_pkg::PH_R7;
                    st_next.byte_counter = 10'd0;
                    st_next.response_shift = 32'd0;
                    st_next.capacity_field = 22'd0;
                end else begin fin = 1'b1; fin_code = sds_pkg::ST_CMD8; end
                sds_pkg::PH_CMD55A: if (r1 == 8'd1) begin
                    begin_frame = 1'b1; nph = sds_pkg::PH_ACMD41A;
                    narg = sds_pkg::ARG_ACMD41;
                end else begin fin = 1'b1; fin_code = sds_pkg::ST_CMD55A; end
                sds_pkg::PH_ACMD41A: begin
                    begin_frame = 1'b1;
                    if (r1 == 8'd1) begin
                        st_next.acmd_retry = 16'd0; nph = sds_pkg::PH_CMD55L;
                    end else nph = sds_pkg::PH_CMD58;
                end
                sds_pkg::PH_CMD55L: begin
                    if (r1 != 8'd1) begin fin = 1'b1; fin_code = sds_pkg::ST_CMD55L; end
                    else if ({1'b0, st.acmd_retry} + 17'd1 >= {1'b0, lim}) begin
                        fin = 1'b1; fin_code = sds_pkg::ST_RETRY;
                    end else begin
                        begin_frame = 1'b1; nph = sds_pkg::PH_ACMD41L;
                        narg = sds_pkg::ARG_ACMD41;
                    end
                end
                sds_pkg::PH_ACMD41L: begin
                    begin_frame = 1'b1;
                    if (r1 == 8'd0) nph = sds_pkg::PH_CMD58;
                    else begin
                        st_next.acmd_retry = st.acmd_retry + 16'd1;
                        nph = sds_pkg::PH_CMD55L;
                    end
                end
                sds_pkg::PH_CMD58: if (r1 == 8'd0) begin
                    st_next.phase = sds_pkg::PH_OCR;
                    st_next.byte_counter = 10'd0;
                    st_next.response_shift = 32'd0;
                    st_next.capacity_field = 22'd0;
                end else begin fin = 1'b1; fin_code = sds_pkg::ST_CMD58; end
                sds_pkg::PH_CMD16: begin
                    fin = 1'b1;
                    fin_code = (r1 == 8'd0) ? sds_pkg::ST_OK : sds_pkg::ST_CMD16;
                end
                sds_pkg::PH_CMD9, sds_pkg::PH_CMD17: if (r1 == 8'd0) begin
                    st_next.phase = (st.phase == sds_pkg::PH_CMD9) ?
                                    sds_pkg::PH_TOKEN_COUNT : sds_pkg::PH_TOKEN_READ;
                    st_next.poll_counter = 16'd1;
                end else begin fin = 1'b1; fin_code = sds_pkg::ST_R1; end
                default: if (r1 == 8'd0) begin
                    st_next.phase = sds_pkg::PH_WDATA;
                    st_next.byte_counter = 10'd0;
                    res.transmit_byte = start_token;
                    res.need_write_byte = 1'b1;
                end else begin fin = 1'b1; fin_code = sds_pkg::ST_R1; end
            endcase
        end

        if (begin_frame) begin
            st_next.phase = nph;
            st_next.command_argument = narg;
            st_next.byte_counter = 10'd1;
            res.transmit_byte = {2'b01, cmd_index(nph)};
        end

        if (fin) begin
            st_next.phase = sds_pkg::PH_IDLE;
            st_next.byte_counter = 10'd0;
            st_next.poll_counter = 16'd0;
            res.transmit_byte = sds_pkg::IDLE_BYTE;
            res.select_active = 1'b0;
            res.status = fin_code;
            res.last = 1'b1;
            if (st.phase == sds_pkg::PH_CSD) res.block_count = {cap_sum, 10'd0};
        end
    end

endmodule

### rtl/core/sd_card_spi_host_sequencer.sv
//------------------------------------------------------------------------------
// sd_card_spi_host_sequencer
// SD card SPI-mode host sequencer, stepped once per byte exchange.
//------------------------------------------------------------------------------
// Usage: each item on the s_ channel is one step. A start command (init,
// block count, read, write) begins an operation; continuation items carry the
// byte the card returned in the previous exchange, or the next payload byte
// of a block write. Each item produces exactly one result item on the m_
// channel naming the next byte to shift out, the chip select level, any read
// data, a request for a write byte, the status and the operation's end flag.
// An accepted item is decoded against the sequencer state register and its
// result is written to the output register at the edge that accepts it. One
// item per cycle is sustained while the receiver takes each result; the state
// update is a single pass of combinational logic. When the receiver stalls,
// the output register holds its item and s_tready stays high only if that
// register is being emptied in the same cycle. Reset returns the sequencer to
// idle with all counters cleared, poll_limit to 1000 and start_token to 0xFE,
// and empties the output register. Configuration writes are always accepted.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sd_card_spi_host_sequencer_macros.svh"

module sd_card_spi_host_sequencer #(
    parameter int BLOCK_BYTES = 512,
    parameter int PRIME_BYTES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] command, [34:3] block_address, [42:35] received_byte,
    // [50:43] write_byte, [55:51] zero
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] transmit_byte, [8] select_active, [16:9] read_byte,
    // [17] read_valid, [18] need_write_byte, [22:19] status,
    // [54:23] block_count, [55] zero
    output logic [55:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    sds_pkg::seq_state_t st_reg, st_next;
    sds_pkg::result_t    res_next, res_reg;
    logic                out_valid_reg;
    logic [15:0]         poll_limit_reg;
    logic [7:0]          start_token_reg;
    logic                in_fire;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    sds_step #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .PRIME_BYTES(PRIME_BYTES)
    ) u_step (
        .st           (st_reg),
        .command      (s_tdata[2:0]),
        .block_address(s_tdata[34:3]),
        .received_byte(s_tdata[42:35]),
        .write_byte   (s_tdata[50:43]),
        .poll_limit   (poll_limit_reg),
        .start_token  (start_token_reg),
        .st_next      (st_next),
        .res          (res_next)
    );

    // The idle phase encodes as zero, so clearing the state register idles it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg          <= '0;
            out_valid_reg   <= 1'b0;
            poll_limit_reg  <= 16'd1000;
            start_token_reg <= 8'hFE;
        end else begin
            if (in_fire) begin
                st_reg        <= st_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    sds_pkg::CFG_POLL_LIMIT:  poll_limit_reg  <= cfg_data;
                    sds_pkg::CFG_START_TOKEN: start_token_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_fire) res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {1'b0, res_reg.block_count, res_reg.status, res_reg.need_write_byte,
                       res_reg.read_valid, res_reg.read_byte, res_reg.select_active,
                       res_reg.transmit_byte};

    `SDS_ASSERT_IMP(a_last_releases_cs, aclk, aresetn, m_tvalid && m_tlast,
        !m_tdata[8] && m_tdata[7:0] == 8'hFF, "final item must release chip select")
    `SDS_ASSERT_IMP(a_busy_not_last, aclk, aresetn, m_tvalid && !m_tlast,
        m_tdata[22:19] == sds_pkg::ST_BUSY, "status set on a non-final item")
    `SDS_ASSERT_NEXT(a_last_idle, aclk, aresetn, in_fire && res_next.last,
        st_reg.phase == sds_pkg::PH_IDLE, "sequencer not idle after final item")
    `SDS_ASSERT_IMP(a_read_no_write, aclk, aresetn, m_tvalid && m_tdata[17],
        !m_tdata[18], "read data and write request together")

endmodule
